// ----- hdl/mctt_pkg.sv -----
// shared constants for the multi-console text terminal
// field widths, character codes, action codes and default geometry; no dependencies
package mctt_pkg;

    // default geometry, handed to the top level parameters
    localparam int COLUMNS_DEF  = 80;
    localparam int ROWS_DEF     = 25;
    localparam int CONSOLES_DEF = 4;

    // beat field widths
    localparam int ACTION_W  = 2;
    localparam int CHAR_W    = 8;
    localparam int SELECT_W  = 8;
    localparam int INDEX_W   = 11;
    localparam int POS_W     = 11;
    localparam int NUMBER_W  = 2;
    localparam int CELL_W    = 16;
    localparam int ATTR_W    = 8;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_PRINT  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SWITCH = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

    // character codes
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DIGIT_ONE = 8'h31;

    // attribute after reset and number of consoles that carry a digit label
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;
    localparam int                LABELS     = 4;

endpackage

// ----- hdl/mctt_agu.sv -----
// shared address unit: console base plus cell offset, with loop end compare
// parameterized by address and offset widths; no package dependency
module mctt_agu #(
    parameter int AW = 13,
    parameter int PW = 11
) (
    input  logic [AW-1:0] i_base,
    input  logic [PW-1:0] i_offset,
    input  logic [PW-1:0] i_last,
    output logic [AW-1:0] o_addr,
    output logic          o_end
);

    assign o_addr = i_base + AW'(i_offset);
    assign o_end  = (i_offset == i_last);

endmodule

// ----- hdl/mctt_store.sv -----
// cell store for all consoles: one write port, one read port with registered data
// depends on mctt_pkg for the cell width
module mctt_store #(
    parameter int DEPTH = 8000,
    parameter int AW    = 13
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [mctt_pkg::CELL_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [mctt_pkg::CELL_W-1:0] o_rdata
);

    logic [mctt_pkg::CELL_W-1:0] r_mem [DEPTH];
    logic [mctt_pkg::CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/multi_console_text_terminal.sv -----
// top level of the multi-console text terminal: sequencer, cursors and result register
// depends on mctt_pkg, mctt_agu and mctt_store
//
// Text terminal with CONSOLES screens of ROWS x COLUMNS cells (attribute byte high,
// character byte low), one cursor per console and one active console. After reset the
// block runs a clearing pass over all CONSOLES*ROWS*COLUMNS cells (8000 at the default
// geometry) that fills every cell with a blank and puts the digits 1 to 4 in cell 0 of
// the first four consoles; no beat is taken meanwhile, attribute writes are. The block
// works on one beat at a time and raises o_in_stall until its result is in the output
// register, which can still be waiting while the next beat is taken. Every cell access
// goes through one shared address adder and the cell store, whose read and write ports
// share that address. A cell read waits for the registered store read, and a scroll
// copies each cell below the top row one row up, a read and then a write per cell, and
// then blanks the bottom row with the current attribute. A result that waits in the
// output register holds the block in its last step.
module multi_console_text_terminal #(
    parameter int COLUMNS  = mctt_pkg::COLUMNS_DEF,
    parameter int ROWS     = mctt_pkg::ROWS_DEF,
    parameter int CONSOLES = mctt_pkg::CONSOLES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // attribute register
    input  logic                          i_cfg_wr_en,
    input  logic [mctt_pkg::ATTR_W-1:0]   i_cfg_wr_data,
    // input beats
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [mctt_pkg::ACTION_W-1:0] i_action,
    input  logic [mctt_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [mctt_pkg::SELECT_W-1:0] i_console_select,
    input  logic [mctt_pkg::INDEX_W-1:0]  i_cell_index,
    // result beats
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [mctt_pkg::POS_W-1:0]    o_cursor_position,
    output logic [mctt_pkg::NUMBER_W-1:0] o_active_number,
    output logic [mctt_pkg::CELL_W-1:0]   o_cell_value,
    output logic                          o_scrolled
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int DEPTH  = CONSOLES * CELLS;
    localparam int COPY_N = (ROWS - 1) * COLUMNS;
    localparam int AW     = $clog2(DEPTH);
    localparam int PW     = $clog2(CELLS);
    localparam int RW     = $clog2(ROWS);
    localparam int CW     = $clog2(COLUMNS);
    localparam int KW     = $clog2(CONSOLES);

    // sequencer states
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_WRITE = 4'd2;
    localparam logic [3:0] S_READ  = 4'd3;
    localparam logic [3:0] S_RWAIT = 4'd4;
    localparam logic [3:0] S_CP_RD = 4'd5;
    localparam logic [3:0] S_CP_WR = 4'd6;
    localparam logic [3:0] S_BLANK = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    // control state
    logic [3:0]                  r_state,  n_state;
    logic [mctt_pkg::ATTR_W-1:0] r_attr,   n_attr;
    logic [KW-1:0]               r_active, n_active;
    logic [RW-1:0]               r_cur_row [CONSOLES];
    logic [RW-1:0]               n_cur_row [CONSOLES];
    logic [CW-1:0]               r_cur_col [CONSOLES];
    logic [CW-1:0]               n_cur_col [CONSOLES];
    logic [PW-1:0]               r_off,     n_off;
    logic [KW-1:0]               r_clr_con, n_clr_con;
    logic                        r_scroll,  n_scroll;
    logic                        r_out_valid, n_out_valid;

    // payload
    logic [AW-1:0]                 r_base,   n_base;
    logic [mctt_pkg::CELL_W-1:0]   r_wdata,  n_wdata;
    logic [mctt_pkg::CELL_W-1:0]   r_value,  n_value;
    logic [mctt_pkg::POS_W-1:0]    r_o_pos,  n_o_pos;
    logic [mctt_pkg::NUMBER_W-1:0] r_o_num,  n_o_num;
    logic [mctt_pkg::CELL_W-1:0]   r_o_cell, n_o_cell;
    logic                          r_o_scr,  n_o_scr;

    // cursor of the active console
    logic [RW-1:0] cur_row;
    logic [CW-1:0] cur_col;
    logic [PW-1:0] cur_pos;
    logic          last_row;
    logic          last_col;

    // shared address unit and store
    logic [AW-1:0]               agu_base;
    logic [PW-1:0]               agu_off;
    logic [PW-1:0]               agu_last;
    logic [AW-1:0]               agu_addr;
    logic                        agu_end;
    logic                        mem_we;
    logic [mctt_pkg::CELL_W-1:0] mem_wdata;
    logic                        mem_re;
    logic [mctt_pkg::CELL_W-1:0] mem_rdata;

    logic in_acc;
    logic out_free;

    assign cur_row  = r_cur_row[r_active];
    assign cur_col  = r_cur_col[r_active];
    assign cur_pos  = PW'(cur_row) * PW'(COLUMNS) + PW'(cur_col);
    assign last_row = (cur_row == RW'(ROWS - 1));
    assign last_col = (cur_col == CW'(COLUMNS - 1));

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // address unit operands: console base plus offset, end compare per loop
    always_comb begin
        agu_base = r_base;
        agu_off  = r_off;
        agu_last = PW'(CELLS - 1);
        case (r_state)
            S_CLEAR: begin
                agu_base = AW'(r_clr_con) * AW'(CELLS);
            end
            S_CP_RD: begin
                // source cell sits one row below the destination
                agu_off = r_off + PW'(COLUMNS);
            end
            S_CP_WR: begin
                agu_last = PW'(COPY_N - 1);
            end
            default: begin
            end
        endcase
    end

    mctt_agu #(
        .AW (AW),
        .PW (PW)
    ) u_agu (
        .i_base   (agu_base),
        .i_offset (agu_off),
        .i_last   (agu_last),
        .o_addr   (agu_addr),
        .o_end    (agu_end)
    );

    // store port control
    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_wdata = r_wdata;
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                // digit label in cell 0 of the first consoles, blank elsewhere
                if ((r_off == '0) && (32'(r_clr_con) < mctt_pkg::LABELS)) begin
                    mem_wdata = {mctt_pkg::ATTR_RESET,
                                 mctt_pkg::CH_DIGIT_ONE + mctt_pkg::CHAR_W'(r_clr_con)};
                end else begin
                    mem_wdata = {mctt_pkg::ATTR_RESET, mctt_pkg::CH_SPACE};
                end
            end
            S_WRITE: begin
                mem_we = 1'b1;
            end
            S_READ, S_CP_RD: begin
                mem_re = 1'b1;
            end
            S_CP_WR: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
            end
            S_BLANK: begin
                mem_we    = 1'b1;
                mem_wdata = {r_attr, mctt_pkg::CH_SPACE};
            end
            default: begin
            end
        endcase
    end

    mctt_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (agu_addr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (agu_addr),
        .o_rdata (mem_rdata)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_attr      = r_attr;
        n_active    = r_active;
        n_cur_row   = r_cur_row;
        n_cur_col   = r_cur_col;
        n_off       = r_off;
        n_clr_con   = r_clr_con;
        n_scroll    = r_scroll;
        n_base      = r_base;
        n_wdata     = r_wdata;
        n_value     = r_value;
        n_o_pos     = r_o_pos;
        n_o_num     = r_o_num;
        n_o_cell    = r_o_cell;
        n_o_scr     = r_o_scr;
        n_out_valid = r_out_valid;

        if (i_cfg_wr_en) begin
            n_attr = i_cfg_wr_data;
        end
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                if (agu_end) begin
                    n_off = '0;
                    if (r_clr_con == KW'(CONSOLES - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_clr_con = r_clr_con + 1'b1;
                    end
                end else begin
                    n_off = r_off + 1'b1;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_base   = AW'(r_active) * AW'(CELLS);
                    n_scroll = 1'b0;
                    n_value  = '0;
                    n_state  = S_DONE;
                    case (i_action)
                        mctt_pkg::ACT_PRINT: begin
                            if (i_char_code == mctt_pkg::CH_BACKSPACE) begin
                                if (cur_col == '0) begin
                                    // wrap to end of previous row (end of row 0 on the top row), no erase
                                    n_cur_row[r_active] = last_row ? cur_row - 1'b1 :
                                                          (cur_row == '0) ? '0 :
                                                          cur_row - 1'b1;
                                    n_cur_col[r_active] = CW'(COLUMNS - 1);
                                end else begin
                                    n_cur_col[r_active] = cur_col - 1'b1;
                                    n_off   = cur_pos - 1'b1;
                                    n_wdata = {r_attr, mctt_pkg::CH_SPACE};
                                    n_state = S_WRITE;
                                end
                            end else if (i_char_code == mctt_pkg::CH_NEWLINE) begin
                                n_cur_col[r_active] = '0;
                                if (last_row) begin
                                    n_scroll = 1'b1;
                                    n_off    = '0;
                                    n_state  = S_CP_RD;
                                end else begin
                                    n_cur_row[r_active] = cur_row + 1'b1;
                                end
                            end else begin
                                n_off   = cur_pos;
                                n_wdata = {r_attr, i_char_code};
                                n_state = S_WRITE;
                                if (last_col) begin
                                    n_cur_col[r_active] = '0;
                                    if (last_row) begin
                                        n_scroll = 1'b1;
                                    end else begin
                                        n_cur_row[r_active] = cur_row + 1'b1;
                                    end
                                end else begin
                                    n_cur_col[r_active] = cur_col + 1'b1;
                                end
                            end
                        end
                        mctt_pkg::ACT_SWITCH: begin
                            // out-of-range console is ignored
                            if (32'(i_console_select) < CONSOLES) begin
                                n_active = KW'(i_console_select);
                            end
                        end
                        mctt_pkg::ACT_READ: begin
                            if (32'(i_cell_index) < CELLS) begin
                                n_off   = PW'(i_cell_index);
                                n_state = S_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WRITE: begin
                // a wrap off the bottom row scrolls after the character lands
                if (r_scroll) begin
                    n_off   = '0;
                    n_state = S_CP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                n_state = S_RWAIT;
            end
            S_RWAIT: begin
                n_value = mem_rdata;
                n_state = S_DONE;
            end
            S_CP_RD: begin
                n_state = S_CP_WR;
            end
            S_CP_WR: begin
                n_off = r_off + 1'b1;
                if (agu_end) begin
                    n_state = S_BLANK;
                end else begin
                    n_state = S_CP_RD;
                end
            end
            S_BLANK: begin
                if (agu_end) begin
                    n_state = S_DONE;
                end else begin
                    n_off = r_off + 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_o_pos     = mctt_pkg::POS_W'(cur_pos);
                    n_o_num     = mctt_pkg::NUMBER_W'(r_active);
                    n_o_cell    = r_value;
                    n_o_scr     = r_scroll;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_attr      <= mctt_pkg::ATTR_RESET;
            r_active    <= '0;
            r_off       <= '0;
            r_clr_con   <= '0;
            r_scroll    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < CONSOLES; k++) begin
                r_cur_row[k] <= '0;
                r_cur_col[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_attr      <= n_attr;
            r_active    <= n_active;
            r_off       <= n_off;
            r_clr_con   <= n_clr_con;
            r_scroll    <= n_scroll;
            r_out_valid <= n_out_valid;
            r_cur_row   <= n_cur_row;
            r_cur_col   <= n_cur_col;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_base   <= n_base;
        r_wdata  <= n_wdata;
        r_value  <= n_value;
        r_o_pos  <= n_o_pos;
        r_o_num  <= n_o_num;
        r_o_cell <= n_o_cell;
        r_o_scr  <= n_o_scr;
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_cursor_position = r_o_pos;
    assign o_active_number   = r_o_num;
    assign o_cell_value      = r_o_cell;
    assign o_scrolled        = r_o_scr;

    // no result can appear before the clearing pass is over
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_out_valid)
        else $error("result beat during clearing pass");

    // active cursor stays on the screen
    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_cur_row[r_active]) < ROWS) && (32'(r_cur_col[r_active]) < COLUMNS))
        else $error("cursor off screen");

    // active console always exists
    a_active_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_active) < CONSOLES)
        else $error("active console out of range");

    // every copy read is followed by its write
    a_copy_pairs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CP_RD) |=> (r_state == S_CP_WR))
        else $error("scroll copy read without write");

    // a scrolled result leaves the cursor at the start of the bottom row
    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_scr) |-> (r_o_pos == mctt_pkg::POS_W'(COPY_N)))
        else $error("scroll left cursor elsewhere");

endmodule
